@@ src/assert_macros.svh @@
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge out of reset
`define LCFB_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("implication check failed");

// expression that must hold at every rising clock edge out of reset
`define LCFB_ASSERT_ALWAYS(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("invariant check failed");

`endif

@@ src/lcfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lcfb_pkg;

    typedef enum logic [1:0] {
        OP_HEADER = 2'd0,
        OP_PIXEL  = 2'd1,
        OP_SYNC   = 2'd2,
        OP_BRIGHT = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        REG_ORDER_FIRST  = 2'd0,
        REG_ORDER_SECOND = 2'd1,
        REG_ORDER_THIRD  = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    localparam int COUNT_W  = 9;
    localparam int LEVEL_W  = 16;
    localparam int PIXEL_LEN = 3;
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // frame byte positions
    localparam int MAC_LEN  = 12;
    localparam int TYPE_AT  = 12;
    localparam int DATA_AT  = 13;

    localparam logic [7:0] TYPE_PIX = 8'h55;
    localparam logic [7:0] TYPE_SYN = 8'h01;
    localparam logic [7:0] TYPE_BRT = 8'h0A;
    localparam logic [7:0] HDR_TAIL0 = 8'h08;
    localparam logic [7:0] HDR_TAIL1 = 8'h88;
    localparam logic [7:0] SYN_MARK0 = 8'h07;
    localparam logic [7:0] SYN_MARK1 = 8'h05;

    // destination then source address
    localparam logic [7:0] MAC_HEAD [MAC_LEN] = '{
        8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
        8'h22, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66
    };

    typedef struct packed {
        opcode_t              kind;
        logic [15:0]          row;
        logic [15:0]          first;
        logic [COUNT_W-1:0]   count;
        logic [7:0]           bright;
        logic [7:0]           px0;
        logic [7:0]           px1;
        logic [7:0]           px2;
        logic                 last;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic nonempty;
    } q_stat_t;

endpackage
`default_nettype wire

@@ src/lcfb_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcfb_front #(
    parameter int MAX_PIXELS = 497
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [1:0]              cfg_wdata,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire lcfb_pkg::opcode_t       opcode,
    input  wire logic [15:0]             row_number,
    input  wire logic [15:0]             first_pixel,
    input  wire logic [8:0]              pixel_count,
    input  wire logic [15:0]             level,
    input  wire logic [7:0]              source_channel_0,
    input  wire logic [7:0]              source_channel_1,
    input  wire logic [7:0]              source_channel_2,
    input  wire lcfb_pkg::q_stat_t       q_stat,
    output logic                         push,
    output lcfb_pkg::cmd_t               push_cmd,
    output logic                         remaining_zero
);
    import lcfb_pkg::*;

    logic [1:0]         order_first_reg, order_second_reg, order_third_reg;
    logic [COUNT_W-1:0] remaining_reg, remaining_next;
    logic [COUNT_W-1:0] count_sat;
    logic [7:0]         bright;
    logic               accept;

    function automatic logic [7:0] pick(input logic [1:0] sel, input logic [7:0] c0,
                                        input logic [7:0] c1, input logic [7:0] c2);
        logic [7:0] r;
        case (sel)
            2'd0:    r = c0;
            2'd1:    r = c1;
            2'd2:    r = c2;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    assign in_ready       = !q_stat.full;
    assign accept         = in_valid && in_ready;
    assign remaining_zero = (remaining_reg == '0);

    assign count_sat = (pixel_count > COUNT_W'(MAX_PIXELS)) ? COUNT_W'(MAX_PIXELS)
                                                            : pixel_count;

    always_comb begin
        if (level[15]) begin
            bright = 8'h00;
        end else if (level[14:8] != '0) begin
            bright = 8'hFF;
        end else begin
            bright = level[7:0];
        end
    end

    always_comb begin
        push_cmd.kind   = opcode;
        push_cmd.row    = row_number;
        push_cmd.first  = first_pixel;
        push_cmd.count  = count_sat;
        push_cmd.bright = bright;
        push_cmd.px0    = pick(order_first_reg, source_channel_0, source_channel_1,
                               source_channel_2);
        push_cmd.px1    = pick(order_second_reg, source_channel_0, source_channel_1,
                               source_channel_2);
        push_cmd.px2    = pick(order_third_reg, source_channel_0, source_channel_1,
                               source_channel_2);
        push_cmd.last   = 1'b1;
        push            = accept;
        remaining_next  = remaining_reg;
        unique case (opcode) inside
            OP_HEADER: begin
                push_cmd.last  = (count_sat == '0);
                remaining_next = count_sat;
            end
            OP_PIXEL: begin
                // pixel with nothing outstanding is dropped
                push_cmd.last = (remaining_reg == COUNT_W'(1));
                push          = accept && !remaining_zero;
                if (!remaining_zero) begin
                    remaining_next = remaining_reg - COUNT_W'(1);
                end
            end
            OP_SYNC, OP_BRIGHT: begin
                remaining_next = '0;
            end
            default: begin
                remaining_next = remaining_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            remaining_reg    <= '0;
            order_first_reg  <= 2'd0;
            order_second_reg <= 2'd1;
            order_third_reg  <= 2'd2;
        end else begin
            if (accept) begin
                remaining_reg <= remaining_next;
            end
            if (cfg_wr_en) begin
                case (reg_index_t'(cfg_index))
                    REG_ORDER_FIRST:  order_first_reg  <= cfg_wdata;
                    REG_ORDER_SECOND: order_second_reg <= cfg_wdata;
                    REG_ORDER_THIRD:  order_third_reg  <= cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

endmodule
`default_nettype wire

@@ src/lcfb_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcfb_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire lcfb_pkg::cmd_t     push_cmd,
    input  wire logic               pop,
    output lcfb_pkg::cmd_t          head_cmd,
    output lcfb_pkg::q_stat_t       q_stat
);
    import lcfb_pkg::*;

    cmd_t               mem [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    logic               do_push, do_pop;

    assign q_stat.full     = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign q_stat.nonempty = (count_reg != '0);
    assign do_push         = push && !q_stat.full;
    assign do_pop          = pop && q_stat.nonempty;
    assign head_cmd        = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (QPTR_W+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_W+1)'(1);
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/lcfb_back.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lcfb_back #(
    parameter int PIXEL_HEADER_LEN = 21,
    parameter int SYNC_FRAME_LEN   = 64,
    parameter int BRIGHT_FRAME_LEN = 64
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire lcfb_pkg::cmd_t     head_cmd,
    input  wire lcfb_pkg::q_stat_t  q_stat,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              out_byte,
    output logic                    end_of_frame,
    output logic                    busy
);
    import lcfb_pkg::*;

    localparam int MaxA   = (PIXEL_HEADER_LEN > SYNC_FRAME_LEN) ? PIXEL_HEADER_LEN
                                                                : SYNC_FRAME_LEN;
    localparam int MaxLen = (MaxA > BRIGHT_FRAME_LEN) ? MaxA : BRIGHT_FRAME_LEN;
    localparam int IdxW   = $clog2(MaxLen);

    cmd_t            cmd_reg;
    logic            busy_reg;
    logic [IdxW-1:0] idx_reg;
    logic [IdxW-1:0] last_idx;
    logic            at_last;
    logic            out_free;
    logic            emit;
    logic            m_valid_reg;
    logic [7:0]      m_byte_reg;
    logic            m_last_reg;

    function automatic logic [7:0] frame_byte(input cmd_t c, input logic [IdxW-1:0] i);
        logic [7:0] b;
        b = 8'h00;
        if (c.kind == OP_PIXEL) begin
            case (i)
                IdxW'(0): b = c.px0;
                IdxW'(1): b = c.px1;
                default:  b = c.px2;
            endcase
        end else if (i < IdxW'(MAC_LEN)) begin
            b = MAC_HEAD[i[3:0]];
        end else if (i == IdxW'(TYPE_AT)) begin
            unique case (c.kind)
                OP_HEADER: b = TYPE_PIX;
                OP_SYNC:   b = TYPE_SYN;
                default:   b = TYPE_BRT;
            endcase
        end else begin
            unique case (c.kind)
                OP_HEADER: begin
                    case (i)
                        IdxW'(DATA_AT + 0): b = c.row[15:8];
                        IdxW'(DATA_AT + 1): b = c.row[7:0];
                        IdxW'(DATA_AT + 2): b = c.first[15:8];
                        IdxW'(DATA_AT + 3): b = c.first[7:0];
                        IdxW'(DATA_AT + 4): b = 8'(c.count[COUNT_W-1:8]);
                        IdxW'(DATA_AT + 5): b = c.count[7:0];
                        IdxW'(DATA_AT + 6): b = HDR_TAIL0;
                        IdxW'(DATA_AT + 7): b = HDR_TAIL1;
                        default:            b = 8'h00;
                    endcase
                end
                OP_SYNC: begin
                    case (i)
                        IdxW'(DATA_AT + 0):  b = SYN_MARK0;
                        IdxW'(DATA_AT + 22): b = c.bright;
                        IdxW'(DATA_AT + 23): b = SYN_MARK1;
                        IdxW'(DATA_AT + 25): b = c.bright;
                        IdxW'(DATA_AT + 26): b = c.bright;
                        IdxW'(DATA_AT + 27): b = c.bright;
                        default:             b = 8'h00;
                    endcase
                end
                default: begin
                    case (i)
                        IdxW'(DATA_AT + 0): b = c.bright;
                        IdxW'(DATA_AT + 1): b = c.bright;
                        IdxW'(DATA_AT + 2): b = c.bright;
                        default:            b = 8'h00;
                    endcase
                end
            endcase
        end
        return b;
    endfunction

    always_comb begin
        unique case (cmd_reg.kind)
            OP_HEADER: last_idx = IdxW'(PIXEL_HEADER_LEN - 1);
            OP_PIXEL:  last_idx = IdxW'(PIXEL_LEN - 1);
            OP_SYNC:   last_idx = IdxW'(SYNC_FRAME_LEN - 1);
            default:   last_idx = IdxW'(BRIGHT_FRAME_LEN - 1);
        endcase
    end

    assign at_last  = (idx_reg == last_idx);
    assign out_free = !m_valid_reg || out_ready;
    assign emit     = busy_reg && out_free;
    // next command loads as the last word of the current one goes out
    assign pop      = q_stat.nonempty && (!busy_reg || (emit && at_last));

    assign out_valid    = m_valid_reg;
    assign out_byte     = m_byte_reg;
    assign end_of_frame = m_last_reg;
    assign busy         = busy_reg;

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= head_cmd;
        end
        if (emit) begin
            m_byte_reg <= frame_byte(cmd_reg, idx_reg);
            m_last_reg <= cmd_reg.last && at_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (pop) begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
            end else if (emit) begin
                if (at_last) begin
                    busy_reg <= 1'b0;
                end
                idx_reg <= idx_reg + IdxW'(1);
            end
        end
    end

endmodule
`default_nettype wire

@@ src/led_card_frame_builder.sv @@
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tdata row, first pixel, count, level, ch0..ch2; s_tuser opcode
// m_       | out | m_tvalid/m_tready  | m_tdata frame byte; m_tlast end of frame
// cfg_     | in  | cfg_wr_en          | cfg_index, cfg_wdata channel order registers
//
// one frame byte leaves per cycle while m_tready is high and commands wait; a pixel word is 3 bytes,
// a header PIXEL_HEADER_LEN, a sync SYNC_FRAME_LEN and a brightness frame BRIGHT_FRAME_LEN, set by the byte sequencer
// commands enter a four-entry queue at one per cycle while it has room
// reset (aresetn, synchronous, active low) clears the queue, sequencer and pixel count
// a stalled m_ side fills the queue, then s_tready drops
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module led_card_frame_builder #(
    parameter int PIXEL_HEADER_LEN = 21,
    parameter int SYNC_FRAME_LEN   = 64,
    parameter int BRIGHT_FRAME_LEN = 64,
    parameter int MAX_PIXELS       = 497
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [1:0]  cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // row_number[15:0], first_pixel[31:16], pixel_count[40:32], level[56:41],
    // source_channel_0[64:57], source_channel_1[72:65], source_channel_2[80:73], zero fill
    input  wire logic [87:0] s_tdata,
    // opcode[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // out_byte[7:0]
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);
    import lcfb_pkg::*;

    logic    push, pop, remaining_zero, busy;
    cmd_t    push_cmd, head_cmd;
    q_stat_t q_stat;

    lcfb_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .opcode           (opcode_t'(s_tuser)),
        .row_number       (s_tdata[15:0]),
        .first_pixel      (s_tdata[31:16]),
        .pixel_count      (s_tdata[40:32]),
        .level            (s_tdata[56:41]),
        .source_channel_0 (s_tdata[64:57]),
        .source_channel_1 (s_tdata[72:65]),
        .source_channel_2 (s_tdata[80:73]),
        .q_stat           (q_stat),
        .push             (push),
        .push_cmd         (push_cmd),
        .remaining_zero   (remaining_zero)
    );

    lcfb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_stat   (q_stat)
    );

    lcfb_back #(
        .PIXEL_HEADER_LEN (PIXEL_HEADER_LEN),
        .SYNC_FRAME_LEN   (SYNC_FRAME_LEN),
        .BRIGHT_FRAME_LEN (BRIGHT_FRAME_LEN)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head_cmd     (head_cmd),
        .q_stat       (q_stat),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_byte     (m_tdata),
        .end_of_frame (m_tlast),
        .busy         (busy)
    );

    `LCFB_ASSERT_IMP(a_push_needs_accept, aclk, aresetn, push, s_tvalid && s_tready && !q_stat.full)
    `LCFB_ASSERT_IMP(a_drop_idle_pixel, aclk, aresetn, s_tvalid && s_tready && s_tuser == OP_PIXEL && remaining_zero, !push)
    `LCFB_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, pop, q_stat.nonempty)
    `LCFB_ASSERT_IMP(a_pop_starts_busy, aclk, aresetn, pop, ##1 busy)

endmodule
`default_nettype wire

@@ tb/led_card_frame_builder_tb.sv @@
`timescale 1ns / 1ps
module led_card_frame_builder_tb;
    import lcfb_pkg::*;

    localparam int HDR_LEN    = 21;
    localparam int SYNC_LEN   = 64;
    localparam int BRT_LEN    = 64;
    localparam int MAX_PIX    = 497;
    localparam int SETTLE     = 32;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        opcode_t            op;
        logic [15:0]        row_num;
        logic [15:0]        first_px;
        logic [8:0]         count;
        logic signed [15:0] level;
        logic [7:0]         ch0;
        logic [7:0]         ch1;
        logic [7:0]         ch2;
    } cmd_item_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } wire_byte_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_ORDER_FIRST;
    logic [1:0]  cfg_wdata = 2'd0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [87:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = OP_HEADER;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    cmd_item_t  pending_cmds [$];
    wire_byte_t frame_bytes [$];

    // shadow of the block state and the channel order registers
    logic [8:0] pixels_left = '0;
    logic [1:0] order_sel [3] = '{2'd0, 2'd1, 2'd2};
    int         plan_left   = 0;
    int         error_count = 0;

    int tx_burst = 1;
    int tx_gap   = 0;

    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int rx_mode       = 0;
    int rx_mode_left  = 0;
    int rx_tick       = 0;
    logic rx_ready;

    logic [1:0] phase_order [4][3] = '{
        '{2'd2, 2'd1, 2'd0},
        '{2'd3, 2'd0, 2'd1},
        '{2'd1, 2'd3, 2'd2},
        '{2'd0, 2'd2, 2'd3}
    };

    led_card_frame_builder #(
        .PIXEL_HEADER_LEN(HDR_LEN),
        .SYNC_FRAME_LEN  (SYNC_LEN),
        .BRIGHT_FRAME_LEN(BRT_LEN),
        .MAX_PIXELS      (MAX_PIX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #1 aclk = ~aclk;

    function automatic logic [87:0] pack_word(cmd_item_t c);
        return {7'd0, c.ch2, c.ch1, c.ch0, c.level, c.count, c.first_px, c.row_num};
    endfunction

    function automatic logic [7:0] pick_channel(logic [1:0] sel, logic [7:0] c0,
                                                logic [7:0] c1, logic [7:0] c2);
        case (sel)
            2'd0:    return c0;
            2'd1:    return c1;
            2'd2:    return c2;
            default: return 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] clamp_level(logic signed [15:0] lvl);
        if (lvl < 0) return 8'h00;
        if (lvl > 255) return 8'hFF;
        return lvl[7:0];
    endfunction

    // expected wire bytes for one accepted word
    task automatic predict_word(input cmd_item_t c);
        logic [7:0] fb [64];
        logic [7:0] lv;
        logic [8:0] cnt;
        int         len;
        logic       flag;
        foreach (fb[i]) fb[i] = 8'h00;
        for (int i = 0; i < MAC_LEN; i++) fb[i] = MAC_HEAD[i];
        lv   = clamp_level(c.level);
        len  = 0;
        flag = 1'b1;
        case (c.op)
            OP_HEADER: begin
                cnt = (c.count > MAX_PIX) ? 9'(MAX_PIX) : c.count;
                fb[TYPE_AT]   = TYPE_PIX;
                fb[DATA_AT]   = c.row_num[15:8];
                fb[DATA_AT+1] = c.row_num[7:0];
                fb[DATA_AT+2] = c.first_px[15:8];
                fb[DATA_AT+3] = c.first_px[7:0];
                fb[DATA_AT+4] = {7'd0, cnt[8]};
                fb[DATA_AT+5] = cnt[7:0];
                fb[DATA_AT+6] = HDR_TAIL0;
                fb[DATA_AT+7] = HDR_TAIL1;
                pixels_left = cnt;
                len  = HDR_LEN;
                flag = (cnt == 0);
            end
            OP_PIXEL: begin
                // stray pixel with nothing announced is dropped
                if (pixels_left == 0) return;
                fb[0] = pick_channel(order_sel[0], c.ch0, c.ch1, c.ch2);
                fb[1] = pick_channel(order_sel[1], c.ch0, c.ch1, c.ch2);
                fb[2] = pick_channel(order_sel[2], c.ch0, c.ch1, c.ch2);
                pixels_left = pixels_left - 9'd1;
                len  = PIXEL_LEN;
                flag = (pixels_left == 0);
            end
            OP_SYNC: begin
                pixels_left = '0;
                fb[TYPE_AT]    = TYPE_SYN;
                fb[DATA_AT]    = SYN_MARK0;
                fb[DATA_AT+22] = lv;
                fb[DATA_AT+23] = SYN_MARK1;
                fb[DATA_AT+25] = lv;
                fb[DATA_AT+26] = lv;
                fb[DATA_AT+27] = lv;
                len = SYNC_LEN;
            end
            default: begin
                pixels_left = '0;
                fb[TYPE_AT]   = TYPE_BRT;
                fb[DATA_AT]   = lv;
                fb[DATA_AT+1] = lv;
                fb[DATA_AT+2] = lv;
                len = BRT_LEN;
            end
        endcase
        for (int i = 0; i < len; i++)
            frame_bytes.push_back(wire_byte_t'{fb[i], flag && (i == len - 1)});
    endtask

    function automatic cmd_item_t hdr(logic [15:0] row_num, logic [15:0] first_px,
                                      logic [8:0] count);
        return '{OP_HEADER, row_num, first_px, count, 16'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic cmd_item_t pix(logic [7:0] c0, logic [7:0] c1, logic [7:0] c2);
        return '{OP_PIXEL, 16'($urandom), 16'($urandom), 9'($urandom), 16'($urandom),
                 c0, c1, c2};
    endfunction

    function automatic cmd_item_t ctl(opcode_t op, logic signed [15:0] lvl);
        return '{op, 16'($urandom), 16'($urandom), 9'($urandom), lvl,
                 8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic cmd_item_t rand_pix();
        return pix(8'($urandom), 8'($urandom), 8'($urandom));
    endfunction

    function automatic logic signed [15:0] rand_level();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(0, 255));
            1:       return 16'($urandom_range(256, 400));
            2:       return -16'sd1 * 16'($urandom_range(1, 20));
            3: begin
                case ($urandom_range(0, 5))
                    0:       return -16'sd32768;
                    1:       return 16'sd32767;
                    2:       return 16'sd0;
                    3:       return 16'sd255;
                    4:       return 16'sd256;
                    default: return -16'sd1;
                endcase
            end
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly complete packets with random content, some cut short, some stray pixels
    task automatic add_random_cmds(input int n);
        int made;
        int r;
        int cnt;
        int npix;
        made = 0;
        while (made < n) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 511)
                                                  : $urandom_range(0, 10);
                pending_cmds.push_back(hdr(16'($urandom), 16'($urandom), 9'(cnt)));
                made++;
                plan_left = (cnt > MAX_PIX) ? MAX_PIX : cnt;
                npix = plan_left;
                if (npix > 24)
                    npix = $urandom_range(1, 24);
                else if (npix > 0 && $urandom_range(0, 9) == 0)
                    npix = $urandom_range(0, npix - 1);
                repeat (npix) pending_cmds.push_back(rand_pix());
                made      += npix;
                plan_left -= npix;
            end else if (r < 85) begin
                pending_cmds.push_back(ctl($urandom_range(0, 1) ? OP_SYNC : OP_BRIGHT,
                                           rand_level()));
                made++;
                plan_left = 0;
            end else begin
                pending_cmds.push_back(rand_pix());
                if (plan_left > 0) begin
                    plan_left--;
                    made++;
                end
            end
        end
    endtask

    task automatic write_order(input reg_index_t idx, input logic [1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        order_sel[idx] = val;
    endtask

    // dropped pixels leave no bytes, so give the queue time to drain them
    task automatic wait_idle();
        while (pending_cmds.size() != 0 || frame_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // sender: bursts of words with random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_word(pending_cmds[0]);
                void'(pending_cmds.pop_front());
            end
            if (!s_tvalid || s_tready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending_cmds.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= pending_cmds[0].op;
                    s_tdata  <= pack_word(pending_cmds[0]);
                    if (tx_burst > 1) begin
                        tx_burst--;
                    end else begin
                        tx_burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                               : $urandom_range(1, 12);
                        tx_gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: stall pattern changes every so often, plus requested long hold-offs
    always @(posedge aclk) begin
        rx_tick++;
        if (hold_served != hold_requests) begin
            hold_served++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rx_ready = 1'b0;
        end else begin
            if (rx_mode_left == 0) begin
                rx_mode      = $urandom_range(0, 3);
                rx_mode_left = $urandom_range(20, 200);
            end else begin
                rx_mode_left--;
            end
            case (rx_mode)
                0:       rx_ready = 1'b1;
                1:       rx_ready = $urandom_range(0, 1);
                2:       rx_ready = ($urandom_range(0, 3) != 0);
                default: rx_ready = ((rx_tick % 7) < 3);
            endcase
        end
        m_tready <= rx_ready;
    end

    always @(posedge aclk) begin : byte_check
        wire_byte_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (frame_bytes.size() == 0) begin
                $error("unexpected word: out_byte %02h end_of_frame %0b", m_tdata, m_tlast);
                error_count++;
            end else begin
                want = frame_bytes.pop_front();
                if (m_tdata !== want.data) begin
                    $error("out_byte expected %02h actual %02h", want.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("end_of_frame expected %0b actual %0b", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    initial begin
        aresetn <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under the reset channel order
        pending_cmds.push_back(hdr(16'hFFFF, 16'h0000, 9'd0));
        pending_cmds.push_back(hdr(16'h1234, 16'hFFFF, 9'd2));
        pending_cmds.push_back(pix(8'hFF, 8'h00, 8'h80));
        pending_cmds.push_back(pix(8'h01, 8'h02, 8'h03));
        pending_cmds.push_back(pix(8'hAA, 8'h55, 8'hFF));
        pending_cmds.push_back(ctl(OP_SYNC, -16'sd32768));
        pending_cmds.push_back(ctl(OP_SYNC, 16'sd32767));
        pending_cmds.push_back(ctl(OP_BRIGHT, -16'sd1));
        pending_cmds.push_back(ctl(OP_BRIGHT, 16'sd0));
        pending_cmds.push_back(ctl(OP_BRIGHT, 16'sd255));
        pending_cmds.push_back(ctl(OP_BRIGHT, 16'sd256));
        pending_cmds.push_back(ctl(OP_SYNC, 16'sd100));
        // oversized count, then a header that replaces the unfinished one
        pending_cmds.push_back(hdr(16'h0000, 16'h8000, 9'd511));
        pending_cmds.push_back(pix(8'h10, 8'h20, 8'h30));
        pending_cmds.push_back(pix(8'h40, 8'h50, 8'h60));
        pending_cmds.push_back(hdr(16'h00FF, 16'hFF00, 9'd3));
        pending_cmds.push_back(pix(8'h7F, 8'h80, 8'hFE));
        // sync abandons the pending pixels, so the next pixel is dropped
        pending_cmds.push_back(ctl(OP_SYNC, 16'sd5));
        pending_cmds.push_back(pix(8'h11, 8'h22, 8'h33));
        pending_cmds.push_back(hdr(16'h8001, 16'h0001, 9'd497));
        pending_cmds.push_back(pix(8'h00, 8'hFF, 8'h00));
        pending_cmds.push_back(ctl(OP_BRIGHT, 16'sd77));
        pending_cmds.push_back(hdr(16'h5A5A, 16'hA5A5, 9'd1));
        pending_cmds.push_back(pix(8'hC3, 8'h3C, 8'h99));
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            for (int r = 0; r < 3; r++)
                write_order(reg_index_t'(r),
                            (p == 4) ? 2'($urandom_range(0, 3)) : phase_order[p][r]);
            if (p == 1) hold_requests++;
            add_random_cmds(78);
            wait_idle();
        end

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
